// ----- rtl/core/meg_pkg.sv -----
// Package for the midpoint ellipse generator: operation codes, the multiplier
// and decision-term selects, and the command and status structs between the
// controller and the datapath. Depends on nothing.
package meg_pkg;

  localparam logic OP_START = 1'b0;

  typedef enum logic [3:0] {
    MUL_RY2_X,
    MUL_RX2_Y,
    MUL_RX2_RX2,
    MUL_Y_Y,
    MUL_TX_TX,
    MUL_RY2_P,
    MUL_TY_TY,
    MUL_RX2_P,
    MUL_RX2_RY2
  } mul_sel_t;

  typedef enum logic [1:0] {
    D_HOLD,
    D_LOAD,
    D_ADD4,
    D_SUB4
  } d_op_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     cap_a;
    logic     cap_b;
    logic     ld_rx2;
    logic     ld_ry2;
    d_op_t    d_op;
    logic     set_region2;
    logic     emit;
  } meg_cmd_t;

  typedef struct packed {
    logic need_switch;
    logic out_free;
  } meg_status_t;

endpackage

// ----- rtl/core/meg_ctrl.sv -----
// Controller of the midpoint ellipse generator: a one-hot state machine that
// sequences the shared multiplier and the decision-term updates.
// Depends on meg_pkg.
module meg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  meg_pkg::meg_status_t status,
  output meg_pkg::meg_cmd_t    cmd
);
  import meg_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MB   = 13'b0000000000010,
    S_CAP  = 13'b0000000000100,
    S_EMIT = 13'b0000000001000,
    S_T1   = 13'b0000000010000,
    S_T2   = 13'b0000000100000,
    S_T3   = 13'b0000001000000,
    S_W1   = 13'b0000010000000,
    S_W2   = 13'b0000100000000,
    S_W3   = 13'b0001000000000,
    S_W4   = 13'b0010000000000,
    S_W5   = 13'b0100000000000,
    S_W6   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_RY2_X;
    cmd.d_op    = D_HOLD;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.mul_en = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_op == OP_START) ? S_T1 : S_MB;
        end
      end
      S_MB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RX2_Y;
        cmd.cap_a   = 1'b1;
        state_nxt   = S_CAP;
      end
      S_CAP: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.need_switch) begin
          state_nxt = S_W1;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_T1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RX2_RX2;
        state_nxt   = S_T2;
      end
      S_T2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y_Y;
        cmd.ld_rx2  = 1'b1;
        state_nxt   = S_T3;
      end
      S_T3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RX2_Y;
        cmd.ld_ry2  = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_W1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TX_TX;
        state_nxt   = S_W2;
      end
      S_W2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RY2_P;
        state_nxt   = S_W3;
      end
      S_W3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TY_TY;
        cmd.d_op    = D_LOAD;
        state_nxt   = S_W4;
      end
      S_W4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RX2_P;
        state_nxt   = S_W5;
      end
      S_W5: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RX2_RY2;
        cmd.d_op    = D_ADD4;
        state_nxt   = S_W6;
      end
      S_W6: begin
        cmd.d_op        = D_SUB4;
        cmd.set_region2 = 1'b1;
        state_nxt       = S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/meg_datapath.sv -----
// Datapath of the midpoint ellipse generator: walk registers, the shared
// registered multiplier, the decision term and the output register.
// Depends on meg_pkg; driven by meg_ctrl.
module meg_datapath #(
  parameter int COORD_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  meg_pkg::meg_cmd_t           cmd,
  output meg_pkg::meg_status_t        status,
  input  logic                        in_op,
  input  logic [COORD_BITS-1:0]       in_center_x,
  input  logic [COORD_BITS-1:0]       in_center_y,
  input  logic [COORD_BITS-1:0]       in_radius_x,
  input  logic [COORD_BITS-1:0]       in_radius_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_valid_res,
  output logic                        out_done_res,
  output logic signed [COORD_BITS+1:0] out_right_col,
  output logic signed [COORD_BITS+1:0] out_left_col,
  output logic signed [COORD_BITS+1:0] out_lower_row,
  output logic signed [COORD_BITS+1:0] out_upper_row
);
  import meg_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int SW = 2 * C;
  localparam int OW = C + 2;
  localparam int MA = 2 * C + 1;
  localparam int MB = 2 * C + 4;
  localparam int PW = MA + MB;
  localparam int DW = 4 * C + 8;

  logic                 active_r, active_nxt;
  logic                 region2_r, region2_nxt;
  logic                 start_r, start_nxt;
  logic                 sw_r, sw_nxt;
  logic [C:0]           x_r, x_nxt;
  logic signed [C+1:0]  y_r, y_nxt;
  logic [C-1:0]         cx_r, cx_nxt;
  logic [C-1:0]         cy_r, cy_nxt;
  logic [SW-1:0]        rx2_r, rx2_nxt;
  logic [SW-1:0]        ry2_r, ry2_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  logic signed [DW-1:0] ax_r, ax_nxt;
  logic signed [DW-1:0] by_r, by_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_done_r, res_done_nxt;
  logic signed [OW-1:0] right_r, right_nxt;
  logic signed [OW-1:0] left_r, left_nxt;
  logic signed [OW-1:0] lower_r, lower_nxt;
  logic signed [OW-1:0] upper_r, upper_nxt;

  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic [C+1:0]         tx;
  logic signed [C+1:0]  ty;
  logic signed [DW-1:0] prod_d;
  logic signed [DW-1:0] rx2_d;
  logic signed [DW-1:0] ry2_d;

  assign tx     = {x_r, 1'b1};
  assign ty     = y_r - 1'b1;
  assign prod_d = DW'(prod_r);
  assign rx2_d  = $signed(DW'(rx2_r));
  assign ry2_d  = $signed(DW'(ry2_r));

  always_comb begin
    ma = $signed({1'b0, ry2_r});
    mb = $signed(MB'(x_r));
    case (cmd.mul_sel)
      MUL_RY2_X: begin
        ma = $signed({1'b0, ry2_r});
        mb = $signed(MB'(x_r));
      end
      MUL_RX2_Y: begin
        ma = $signed({1'b0, rx2_r});
        mb = MB'(y_r);
      end
      MUL_RX2_RX2: begin
        ma = $signed({1'b0, rx2_r});
        mb = $signed(MB'(rx2_r));
      end
      MUL_Y_Y: begin
        ma = MA'(y_r);
        mb = MB'(y_r);
      end
      MUL_TX_TX: begin
        ma = $signed(MA'(tx));
        mb = $signed(MB'(tx));
      end
      MUL_RY2_P: begin
        ma = $signed({1'b0, ry2_r});
        mb = prod_r[MB-1:0];
      end
      MUL_TY_TY: begin
        ma = MA'(ty);
        mb = MB'(ty);
      end
      MUL_RX2_P: begin
        ma = $signed({1'b0, rx2_r});
        mb = prod_r[MB-1:0];
      end
      MUL_RX2_RY2: begin
        ma = $signed({1'b0, rx2_r});
        mb = $signed(MB'(ry2_r));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    active_nxt    = active_r;
    region2_nxt   = region2_r;
    start_nxt     = start_r;
    sw_nxt        = sw_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rx2_nxt       = rx2_r;
    ry2_nxt       = ry2_r;
    d_nxt         = d_r;
    ax_nxt        = ax_r;
    by_nxt        = by_r;
    prod_nxt      = cmd.mul_en ? ma * mb : prod_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    res_valid_nxt = res_valid_r;
    res_done_nxt  = res_done_r;
    right_nxt     = right_r;
    left_nxt      = left_r;
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;

    if (cmd.load_in) begin
      start_nxt = (in_op == OP_START);
      if (in_op == OP_START) begin
        cx_nxt  = in_center_x;
        cy_nxt  = in_center_y;
        x_nxt   = '0;
        y_nxt   = $signed((C + 2)'(in_radius_y));
        rx2_nxt = SW'(in_radius_x);
      end
    end
    if (cmd.ld_rx2) begin
      rx2_nxt = prod_r[SW-1:0];
    end
    if (cmd.ld_ry2) begin
      ry2_nxt = prod_r[SW-1:0];
    end
    if (cmd.cap_a) begin
      ax_nxt = prod_d;
    end
    if (cmd.cap_b) begin
      ax_nxt = ax_r + ry2_d;
      by_nxt = prod_d - rx2_d;
      sw_nxt = !(!y_r[C+1] && (ax_r < prod_d));
    end

    case (cmd.d_op)
      D_HOLD: d_nxt = d_r;
      D_LOAD: d_nxt = prod_d;
      D_ADD4: d_nxt = d_r + (prod_d <<< 2);
      D_SUB4: d_nxt = d_r - (prod_d <<< 2);
      default: d_nxt = d_r;
    endcase

    if (cmd.set_region2) begin
      region2_nxt = 1'b1;
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      res_valid_nxt = 1'b0;
      res_done_nxt  = 1'b1;
      right_nxt     = '0;
      left_nxt      = '0;
      lower_nxt     = '0;
      upper_nxt     = '0;
      if (start_r) begin
        res_done_nxt = 1'b0;
        active_nxt   = 1'b1;
        region2_nxt  = 1'b0;
        d_nxt        = (ry2_d <<< 2) - (prod_d <<< 2) + rx2_d;
      end else if (!active_r) begin
        res_done_nxt = 1'b1;
      end else if (region2_r && y_r[C+1]) begin
        active_nxt = 1'b0;
      end else begin
        res_valid_nxt = 1'b1;
        res_done_nxt  = 1'b0;
        right_nxt     = $signed(OW'(cx_r) + OW'(x_r));
        left_nxt      = $signed(OW'(cx_r) - OW'(x_r));
        lower_nxt     = $signed(OW'(cy_r)) + y_r;
        upper_nxt     = $signed(OW'(cy_r)) - y_r;
        if (!region2_r) begin
          x_nxt = x_r + 1'b1;
          if (d_r[DW-1]) begin
            d_nxt = d_r + (ax_r <<< 3) + (ry2_d <<< 2);
          end else begin
            y_nxt = y_r - 1'b1;
            d_nxt = d_r + (ax_r <<< 3) - (by_r <<< 3) + (ry2_d <<< 2);
          end
        end else begin
          y_nxt = y_r - 1'b1;
          if (!d_r[DW-1] && (d_r != '0)) begin
            d_nxt = d_r + (rx2_d <<< 2) - (by_r <<< 3);
          end else begin
            x_nxt = x_r + 1'b1;
            d_nxt = d_r + (ax_r <<< 3) - (by_r <<< 3) + (rx2_d <<< 2);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      region2_r   <= 1'b0;
      start_r     <= 1'b0;
      sw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      region2_r   <= region2_nxt;
      start_r     <= start_nxt;
      sw_r        <= sw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    rx2_r       <= rx2_nxt;
    ry2_r       <= ry2_nxt;
    d_r         <= d_nxt;
    ax_r        <= ax_nxt;
    by_r        <= by_nxt;
    prod_r      <= prod_nxt;
    res_valid_r <= res_valid_nxt;
    res_done_r  <= res_done_nxt;
    right_r     <= right_nxt;
    left_r      <= left_nxt;
    lower_r     <= lower_nxt;
    upper_r     <= upper_nxt;
  end

  assign status.need_switch = !start_r && active_r && sw_r && !region2_r;
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_valid_r;
  assign out_done_res  = res_done_r;
  assign out_right_col = right_r;
  assign out_left_col  = left_r;
  assign out_lower_row = lower_r;
  assign out_upper_row = upper_r;

endmodule

// ----- rtl/core/midpoint_ellipse_generator_unit.sv -----
// Midpoint ellipse rasterizer. A start item (tuser 0) loads the center and the
// radii; each step item (tuser 1) returns the four symmetric pixel coordinates
// of the current point and then advances the walk, or returns the done flag once
// the walk is over. On the step where the walk passes from region one to region
// two, the decision term is first reloaded for region two. One shared signed
// multiplier with a registered product is sequenced by the controller. A result
// waits in an output register, so the block may accept the next item before the
// last result is taken; an item's result leaves only once that register is free.
// Depends on meg_pkg, meg_ctrl and meg_datapath.
module midpoint_ellipse_generator_unit #(
  parameter int COORD_BITS = 10
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // center_x, center_y, radius_x, radius_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  // operation
  input  logic [0:0]                               in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // right_col, left_col, lower_row, upper_row, zero pad
  output logic [((4*(COORD_BITS+2)+7)/8)*8-1:0]    out_tdata,
  // valid_res, done_res
  output logic [1:0]                               out_tuser
);
  import meg_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int OW  = C + 2;
  localparam int ODW = ((4 * OW + 7) / 8) * 8;

  meg_cmd_t    cmd;
  meg_status_t status;

  logic                 res_valid;
  logic                 res_done;
  logic signed [OW-1:0] right_col;
  logic signed [OW-1:0] left_col;
  logic signed [OW-1:0] lower_row;
  logic signed [OW-1:0] upper_row;

  meg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser[0]),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  meg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_op         (in_tuser[0]),
    .in_center_x   (in_tdata[C-1:0]),
    .in_center_y   (in_tdata[2*C-1:C]),
    .in_radius_x   (in_tdata[3*C-1:2*C]),
    .in_radius_y   (in_tdata[4*C-1:3*C]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_valid_res (res_valid),
    .out_done_res  (res_done),
    .out_right_col (right_col),
    .out_left_col  (left_col),
    .out_lower_row (lower_row),
    .out_upper_row (upper_row)
  );

  assign out_tdata = ODW'({upper_row, lower_row, left_col, right_col});
  assign out_tuser = {res_done, res_valid};

  // Once an item is taken, the input stays closed while it is worked on.
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still open after an item was accepted");

  // A result is never loaded over one that has not been taken.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result loaded while the output register was full");

  // The region switch must be finished before a point is produced.
  a_emit_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !status.need_switch)
    else $error("result produced with the region switch still pending");

  // A plotted point and the done flag never come together.
  a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("result marked both plotted and done");

endmodule

// ----- bench/midpoint_ellipse_generator_unit_tb.sv -----
// Self-checking bench for midpoint_ellipse_generator_unit: directed table, then random
// ellipse walks, checked item by item against a predictor of the midpoint walk.
// Depends on meg_pkg and the RTL of midpoint_ellipse_generator_unit.
module midpoint_ellipse_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import meg_pkg::OP_START;

  localparam logic OP_STEP = ~OP_START;
  localparam int ITEM_TARGET = 1050;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic        valid_res;
    logic        done_res;
    logic [11:0] right_col;
    logic [11:0] left_col;
    logic [11:0] lower_row;
    logic [11:0] upper_row;
  } pixel_res_t;

  typedef struct packed {
    logic       op;
    logic [9:0] cx;
    logic [9:0] cy;
    logic [9:0] rx;
    logic [9:0] ry;
    logic       typed;
    pixel_res_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // center_x, center_y, radius_x, radius_y
  logic [39:0] in_tdata;
  // operation
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // right_col, left_col, lower_row, upper_row
  logic [47:0] out_tdata;
  // valid_res, done_res
  logic [1:0]  out_tuser;

  // Predictor state of the ellipse walk.
  bit          walk_active;
  bit          walk_region_two;
  longint      walk_x;
  longint      walk_y;
  logic [63:0] walk_decision;
  logic [63:0] walk_cx;
  logic [63:0] walk_cy;
  logic [63:0] walk_rx2;
  logic [63:0] walk_ry2;

  pixel_res_t  pending_pixels[$];
  stim_row_t   directed_plan[0:23];
  int          mismatch_count;
  int          sent_count;
  bit          hold_results;
  bit          in_idle;
  bit          out_idle;

  midpoint_ellipse_generator_unit #(.COORD_BITS(10)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic pixel_res_t trace_ellipse_step(logic op, logic [9:0] cx, logic [9:0] cy,
                                                    logic [9:0] rx, logic [9:0] ry);
    pixel_res_t  res;
    logic [63:0] ux;
    logic [63:0] uy;
    logic [63:0] tx;
    logic [63:0] ty;
    bit          positive;
    res = '0;
    if (op == OP_START) begin
      walk_cx = 64'(cx);
      walk_cy = 64'(cy);
      walk_rx2 = 64'(rx) * 64'(rx);
      walk_ry2 = 64'(ry) * 64'(ry);
      walk_x = 0;
      walk_y = longint'(ry);
      walk_region_two = 1'b0;
      walk_active = 1'b1;
      walk_decision = 64'd4 * walk_ry2 - 64'd4 * walk_rx2 * 64'(ry) + walk_rx2;
      return res;
    end
    if (!walk_active) begin
      res.done_res = 1'b1;
      return res;
    end
    ux = walk_x;
    uy = walk_y;
    if (!walk_region_two &&
        !(walk_y >= 0 && 64'd2 * walk_ry2 * ux < 64'd2 * walk_rx2 * uy)) begin
      tx = 64'd2 * ux + 64'd1;
      ty = uy - 64'd1;
      walk_region_two = 1'b1;
      walk_decision = walk_ry2 * tx * tx + 64'd4 * walk_rx2 * ty * ty
                      - 64'd4 * walk_rx2 * walk_ry2;
    end
    if (walk_region_two && walk_y < 0) begin
      walk_active = 1'b0;
      res.done_res = 1'b1;
      return res;
    end
    res.valid_res = 1'b1;
    res.right_col = 12'(walk_cx + ux);
    res.left_col = 12'(walk_cx - ux);
    res.lower_row = 12'(walk_cy + uy);
    res.upper_row = 12'(walk_cy - uy);
    if (!walk_region_two) begin
      walk_x += 1;
      ux = walk_x;
      if (walk_decision[63]) begin
        walk_decision += 64'd8 * walk_ry2 * ux + 64'd4 * walk_ry2;
      end else begin
        walk_y -= 1;
        uy = walk_y;
        walk_decision += 64'd8 * walk_ry2 * ux - 64'd8 * walk_rx2 * uy + 64'd4 * walk_ry2;
      end
    end else begin
      positive = !walk_decision[63] && walk_decision != 64'd0;
      walk_y -= 1;
      uy = walk_y;
      if (positive) begin
        walk_decision += 64'd4 * walk_rx2 - 64'd8 * walk_rx2 * uy;
      end else begin
        walk_x += 1;
        ux = walk_x;
        walk_decision += 64'd8 * walk_ry2 * ux - 64'd8 * walk_rx2 * uy + 64'd4 * walk_rx2;
      end
    end
    return res;
  endfunction

  function automatic logic [9:0] pick_radius();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 16) begin
      return 10'($urandom_range(0, 12));
    end else if (sel < 18) begin
      return 10'($urandom_range(13, 60));
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic send_item(logic op, logic [9:0] cx, logic [9:0] cy, logic [9:0] rx,
                           logic [9:0] ry, logic typed, pixel_res_t want);
    int         gap;
    pixel_res_t predicted;
    if ($urandom_range(0, 39) == 0) begin
      in_idle = ~in_idle;
    end
    gap = in_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ry, rx, cy, cx};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    predicted = trace_ellipse_step(op, cx, cy, rx, ry);
    pending_pixels.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  task automatic send_step();
    send_item(OP_STEP, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
              1'b0, '0);
  endtask

  task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_res_t got;
    pixel_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tuser[1], out_tdata[11:0], out_tdata[23:12],
             out_tdata[35:24], out_tdata[47:36]};
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%t: unexpected item, expected none, actual %h", $time, got);
      end else begin
        want = pending_pixels.pop_front();
        check_field("valid_res", 12'(want.valid_res), 12'(got.valid_res));
        check_field("done_res", 12'(want.done_res), 12'(got.done_res));
        check_field("right_col", want.right_col, got.right_col);
        check_field("left_col", want.left_col, got.left_col);
        check_field("lower_row", want.lower_row, got.lower_row);
        check_field("upper_row", want.upper_row, got.upper_row);
      end
    end
  end

  initial begin
    int stall;
    out_tready <= 1'b0;
    out_idle = 1'b1;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) begin
        out_idle = ~out_idle;
      end
      stall = out_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int         steps_done;
    int         step_limit;
    bit         hold_done;
    bit         drain_done;
    logic [9:0] rx;
    logic [9:0] ry;
    // The first rows cover an idle step, zero radii, the largest values with a restart,
    // a vertical line walked to its end, and a flat ellipse.
    directed_plan = '{
      '{OP_STEP,    0,    0,    0,    0, 1'b1, '{1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_START,   0,    0,    0,    0, 1'b1, '{1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_STEP,    0,    0,    0,    0, 1'b1, '{1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_STEP,    0,    0,    0,    0, 1'b1, '{1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_STEP,    0,    0,    0,    0, 1'b1, '{1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_START, 1023, 1023, 1023, 1023, 1'b1, '{1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_STEP,    0,    0,    0,    0, 1'b1,
        '{1'b1, 1'b0, 12'd1023, 12'd1023, 12'd2046, 12'd0}},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_START,   0,    0, 1023, 1023, 1'b1, '{1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_STEP,    0,    0,    0,    0, 1'b1,
        '{1'b1, 1'b0, 12'd0, 12'd0, 12'd1023, -12'sd1023}},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_START,   5,    7,    0,    3, 1'b1, '{1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0},
      '{OP_STEP,    0,    0,    0,    0, 1'b1, '{1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_STEP,    0,    0,    0,    0, 1'b1, '{1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_START, 512,  256,    1,    0, 1'b1, '{1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
      '{OP_STEP,    0,    0,    0,    0, 1'b0, '0}
    };
    walk_active = 1'b0;
    walk_region_two = 1'b0;
    walk_x = 0;
    walk_y = 0;
    walk_decision = '0;
    walk_cx = '0;
    walk_cy = '0;
    walk_rx2 = '0;
    walk_ry2 = '0;
    mismatch_count = 0;
    sent_count = 0;
    hold_results = 1'b0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    in_idle = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      send_item(directed_plan[i].op, directed_plan[i].cx, directed_plan[i].cy,
                directed_plan[i].rx, directed_plan[i].ry, directed_plan[i].typed,
                directed_plan[i].want);
    end

    while (sent_count < ITEM_TARGET) begin
      if (!hold_done && sent_count > 350) begin
        hold_results = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent_count > 700) begin
        in_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        drain_done = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) begin
        send_item(1'($urandom_range(0, 1)), 10'($urandom), 10'($urandom), 10'($urandom),
                  10'($urandom), 1'b0, '0);
      end else begin
        rx = pick_radius();
        ry = pick_radius();
        send_item(OP_START, 10'($urandom), 10'($urandom), rx, ry, 1'b0, '0);
        if (rx > 60 || ry > 60) begin
          step_limit = $urandom_range(1, 30);
        end else if ($urandom_range(0, 3) != 0) begin
          step_limit = 1000;
        end else begin
          step_limit = $urandom_range(0, rx + ry + 2);
        end
        steps_done = 0;
        while (walk_active && steps_done < step_limit) begin
          send_step();
          steps_done++;
        end
        if (!walk_active) begin
          repeat ($urandom_range(0, 2)) send_step();
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/meg_pkg.sv
rtl/core/meg_ctrl.sv
rtl/core/meg_datapath.sv
rtl/core/midpoint_ellipse_generator_unit.sv
bench/midpoint_ellipse_generator_unit_tb.sv
